FILE: design/tcw_pkg.sv
// Shared types, codes and defaults for the text console writer.
package tcw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Widest cell address over the legal geometry range (64 rows of 128 columns).
  localparam int CELL_AW_MAX = 13;

  // Configuration port address width: three 32-bit registers at 0, 4 and 8.
  localparam int PADDR_W = 4;

  // Operation codes.
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Character codes with special handling.
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Register indexes (byte address bits 3:2).
  localparam logic [1:0] REG_COLOR_ATTR   = 2'd0;
  localparam logic [1:0] REG_TAB_WIDTH    = 2'd1;
  localparam logic [1:0] REG_PROMPT_WIDTH = 2'd2;

  // Register reset values.
  localparam logic [7:0] COLOR_ATTR_RST   = 8'd2;
  localparam logic [4:0] TAB_WIDTH_RST    = 5'd4;
  localparam logic [6:0] PROMPT_WIDTH_RST = 7'd8;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } result_t;

  typedef struct packed {
    logic [7:0] color_attr;
    logic [4:0] tab_width;
    logic [6:0] prompt_width;
  } cfg_t;

  // One write port and one read port of the cell memory.
  typedef struct packed {
    logic                   we;
    logic [CELL_AW_MAX-1:0] waddr;
    logic [15:0]            wdata;
    logic                   re;
    logic [CELL_AW_MAX-1:0] raddr;
  } mem_req_t;

endpackage

FILE: design/tcw_regs.sv
// Configuration register file behind the APB-style port.
module tcw_regs import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output cfg_t               cfg
);

  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_attr   <= COLOR_ATTR_RST;
      cfg.tab_width    <= TAB_WIDTH_RST;
      cfg.prompt_width <= PROMPT_WIDTH_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_COLOR_ATTR:   cfg.color_attr   <= pwdata[7:0];
        REG_TAB_WIDTH:    cfg.tab_width    <= pwdata[4:0];
        REG_PROMPT_WIDTH: cfg.prompt_width <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLOR_ATTR:   prdata = 32'(cfg.color_attr);
      REG_TAB_WIDTH:    prdata = 32'(cfg.tab_width);
      REG_PROMPT_WIDTH: prdata = 32'(cfg.prompt_width);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: design/tcw_cell_ram.sv
// Screen cell memory: one write port, one registered read port.
module tcw_cell_ram import tcw_pkg::*; #(
  parameter int DEPTH = ROWS_DEF * COLUMNS_DEF
) (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [15:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [15:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      cells[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= cells[req.raddr[AW-1:0]];
    end
  end

endmodule

FILE: design/tcw_ctrl.sv
// Command sequencer: cursor state, put/clear/read handling and scroll walks.
module tcw_ctrl import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        cmd,
  output logic        busy,
  output logic        done,
  output result_t     result,
  input  cfg_t        cfg,
  output mem_req_t    mem,
  input  logic [15:0] rdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int IXW   = CNT_W + 11;

  localparam logic [CNT_W-1:0] CNT_CELLS = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] CNT_COLS  = CNT_W'(COLUMNS);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'((ROWS - 1) * COLUMNS);
  localparam logic [RW-1:0]    ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0]    COL_END   = CW'(COLUMNS);

  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_READ, ST_COPY, ST_FILL} state_t;

  state_t           state, state_next;
  logic [RW-1:0]    row, row_next;
  logic [CW-1:0]    col, col_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] copy_addr, copy_addr_next;
  logic             copy_valid, copy_valid_next;
  logic             pend, pend_next;
  cmd_t             item;
  logic             emit;
  logic [7:0]       rd_char, rd_attr;
  logic [CNT_W-1:0] pos_next;
  logic [15:0]      blank, char_cell;
  logic [CW-1:0]    col_dec;
  logic [8:0]       tab_sum;

  function automatic logic [CELL_AW_MAX-1:0] cell_addr(input logic [RW-1:0] r,
                                                       input logic [CW-1:0] c);
    logic [CNT_W-1:0] a;
    a = CNT_W'(r) * CNT_COLS + CNT_W'(c);
    return CELL_AW_MAX'(a[AW-1:0]);
  endfunction

  assign busy      = (state != ST_IDLE);
  assign blank     = {cfg.color_attr, CH_SPACE};
  assign char_cell = {cfg.color_attr, item.char_code};
  assign col_dec   = col - 1'b1;
  assign tab_sum   = 9'(col) + 9'(cfg.tab_width);
  assign pos_next  = CNT_W'(row_next) * CNT_COLS + CNT_W'(col_next);

  always_comb begin
    state_next      = state;
    row_next        = row;
    col_next        = col;
    cnt_next        = cnt;
    copy_addr_next  = copy_addr;
    copy_valid_next = 1'b0;
    pend_next       = pend;
    emit            = 1'b0;
    rd_char         = '0;
    rd_attr         = '0;
    mem             = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_next = ST_IDLE;
        unique case (item.operation)
          OP_PUT: begin
            priority if (item.char_code == CH_NEWLINE) begin
              col_next = '0;
              if (row != ROW_LAST) begin
                row_next = row + 1'b1;
                emit     = 1'b1;
              end else begin
                state_next = ST_COPY;
                cnt_next   = CNT_COLS;
                pend_next  = 1'b0;
              end
            end else if (item.char_code == CH_BACKSPACE) begin
              if (9'(col) > 9'(cfg.prompt_width)) begin
                col_next = col_dec;
                // A cursor parked past the last column blanks the last cell.
                if (col_dec < COL_END) begin
                  mem.we    = 1'b1;
                  mem.waddr = cell_addr(row, col_dec);
                  mem.wdata = blank;
                end
              end
              emit = 1'b1;
            end else if (item.char_code == CH_TAB) begin
              col_next = (tab_sum > 9'(COLUMNS)) ? COL_END : CW'(tab_sum);
              emit     = 1'b1;
            end else begin
              if (col >= COL_END) begin
                if (row != ROW_LAST) begin
                  row_next  = row + 1'b1;
                  col_next  = CW'(1);
                  mem.we    = 1'b1;
                  mem.waddr = cell_addr(row + 1'b1, '0);
                  mem.wdata = char_cell;
                  emit      = 1'b1;
                end else begin
                  // Scroll first; the character lands while the last row is blanked.
                  state_next = ST_COPY;
                  cnt_next   = CNT_COLS;
                  pend_next  = 1'b1;
                  col_next   = '0;
                end
              end else begin
                col_next  = col + 1'b1;
                mem.we    = 1'b1;
                mem.waddr = cell_addr(row, col);
                mem.wdata = char_cell;
                emit      = 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            row_next   = '0;
            col_next   = '0;
            cnt_next   = '0;
            pend_next  = 1'b0;
            state_next = ST_FILL;
          end
          OP_READ: begin
            if (IXW'(item.cell_index) < IXW'(CELLS)) begin
              mem.re     = 1'b1;
              mem.raddr  = CELL_AW_MAX'(item.cell_index);
              state_next = ST_READ;
            end else begin
              emit = 1'b1;
            end
          end
          default: emit = 1'b1;
        endcase
      end

      ST_READ: begin
        rd_char    = rdata[7:0];
        rd_attr    = rdata[15:8];
        emit       = 1'b1;
        state_next = ST_IDLE;
      end

      ST_COPY: begin
        // Read one row ahead, write the word returned by the previous read.
        if (copy_valid) begin
          mem.we    = 1'b1;
          mem.waddr = CELL_AW_MAX'(copy_addr[AW-1:0]);
          mem.wdata = rdata;
        end
        if (cnt < CNT_CELLS) begin
          mem.re          = 1'b1;
          mem.raddr       = CELL_AW_MAX'(cnt[AW-1:0]);
          cnt_next        = cnt + 1'b1;
          copy_valid_next = 1'b1;
          copy_addr_next  = cnt - CNT_COLS;
        end else begin
          state_next = ST_FILL;
          cnt_next   = CNT_LAST;
        end
      end

      ST_FILL: begin
        mem.we    = 1'b1;
        mem.waddr = CELL_AW_MAX'(cnt[AW-1:0]);
        mem.wdata = (pend && cnt == CNT_LAST) ? char_cell : blank;
        cnt_next  = cnt + 1'b1;
        if (cnt == CNT_CELLS - 1'b1) begin
          state_next = ST_IDLE;
          emit       = 1'b1;
          if (pend) begin
            col_next = CW'(1);
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      row        <= '0;
      col        <= '0;
      pend       <= 1'b0;
      copy_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      row        <= row_next;
      col        <= col_next;
      pend       <= pend_next;
      copy_valid <= copy_valid_next;
      done       <= emit;
    end
    if (start && !busy) begin
      item <= cmd;
    end
    cnt       <= cnt_next;
    copy_addr <= copy_addr_next;
    if (emit) begin
      result.cursor_pos <= 11'(pos_next);
      result.read_char  <= rd_char;
      result.read_attr  <= rd_attr;
    end
  end

  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_EXEC))
    else $error("accepted command did not enter execution");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= COL_END)
    else $error("cursor column beyond line end");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= ROW_LAST)
    else $error("cursor row beyond last row");

  a_quiet_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_READ) |-> !mem.we)
    else $error("cell write while idle or reading");

endmodule

FILE: design/text_console_writer.sv
// Text console writer top level: command port, APB registers, cell memory.
//
// A command word (operation, char_code, cell_index) is taken at a clock edge
// where start is high and busy is low. Each command returns exactly one
// result word on result, marked by done for a single cycle; the receiver
// cannot stall, so it must take the word in that cycle.
// Steps from the accept edge to the result:
//   put of an ordinary character, backspace, tab, newline without scroll,
//   and unknown operations: a single execute state.
//   read cell: execute and read states; execute only past the last cell.
//   newline or wrap on the last row (scroll): execute, copy and fill states.
//   clear screen: execute and fill states.
// Scroll and clear are bounded by the single write port of the cell memory,
// which moves or blanks one cell per cycle; busy stays high meanwhile.
// Registers (color_attr, tab_width, prompt_width) are to be written over APB
// only while no command is in progress (unenforced); pready is always high.
// Reset homes the cursor and restores register defaults. The cell memory is
// not cleared by reset: issue a clear before reading cells.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cmd_t               cmd,
  output logic               busy,
  output logic               done,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t        cfg;
  mem_req_t    mem;
  logic [15:0] rdata;

  assign pready = 1'b1;

  tcw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tcw_cell_ram #(
    .DEPTH (ROWS * COLUMNS)
  ) u_ram (
    .clk   (clk),
    .req   (mem),
    .rdata (rdata)
  );

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result),
    .cfg    (cfg),
    .mem    (mem),
    .rdata  (rdata)
  );

endmodule

FILE: sim/tb_text_console_writer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text console writer: command port, results and APB registers.
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLS        = COLUMNS_DEF;
  localparam int NROWS       = ROWS_DEF;
  localparam int CELLS       = COLS * NROWS;
  localparam int STALL_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  cmd_t               cmd     = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic               busy;
  logic               done;
  result_t            result;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow copy of the screen, cursor and registers.
  logic [15:0] screen_shadow [CELLS];
  int unsigned row_q;
  int unsigned col_q;
  logic [7:0]  attr_q;
  logic [4:0]  tabw_q;
  logic [6:0]  promptw_q;

  result_t     pending_words [$];
  int          errors = 0;
  int          idle_pct = 30;
  int          newline_pct = 18;
  int          stall_cnt = 0;

  text_console_writer #(.COLUMNS(COLS), .ROWS(NROWS)) uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] blank_cell();
    return {attr_q, CH_SPACE};
  endfunction

  task automatic line_feed();
    col_q = 0;
    if (row_q < NROWS - 1) begin
      row_q++;
    end else begin
      for (int i = 0; i < CELLS - COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_shadow[i] = blank_cell();
    end
  endtask

  // Applies one command to the shadow state and returns the word it must produce.
  task automatic console_apply(input cmd_t c, output result_t r);
    int unsigned nxt;
    r = '0;
    case (c.operation)
      OP_PUT: begin
        case (c.char_code)
          CH_NEWLINE: line_feed();
          CH_BACKSPACE: begin
            if (col_q > promptw_q) begin
              col_q--;
              if (col_q < COLS) screen_shadow[row_q * COLS + col_q] = blank_cell();
            end
          end
          CH_TAB: begin
            nxt = col_q + tabw_q;
            col_q = (nxt > COLS) ? COLS : nxt;
          end
          default: begin
            if (col_q >= COLS) line_feed();
            screen_shadow[row_q * COLS + col_q] = {attr_q, c.char_code};
            col_q++;
          end
        endcase
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_shadow[i] = blank_cell();
        row_q = 0;
        col_q = 0;
      end
      OP_READ: begin
        if (c.cell_index < CELLS) begin
          r.read_char = screen_shadow[c.cell_index][7:0];
          r.read_attr = screen_shadow[c.cell_index][15:8];
        end
      end
      default: ;
    endcase
    r.cursor_pos = 11'(row_q * COLS + col_q);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] exp, input logic [31:0] act);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("MISMATCH %s: expected %0h, got %0h", what, exp, act);
  endtask

  // Sends one command word; start stays high afterwards, so the caller moves on in the same step.
  task automatic send_cmd(input cmd_t c);
    result_t r;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    console_apply(c, r);
    pending_words.push_back(r);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (!wr && prdata !== val) note_mismatch("register read-back", val, prdata);
  endtask

  task automatic set_config(input logic [7:0] attr, input logic [4:0] tabw,
                            input logic [6:0] promptw);
    wait_idle();
    apb_access(1'b1, REG_COLOR_ATTR, {24'd0, attr});
    apb_access(1'b1, REG_TAB_WIDTH, {27'd0, tabw});
    apb_access(1'b1, REG_PROMPT_WIDTH, {25'd0, promptw});
    attr_q    = attr;
    tabw_q    = tabw;
    promptw_q = promptw;
    apb_access(1'b0, REG_COLOR_ATTR, {24'd0, attr});
    apb_access(1'b0, REG_TAB_WIDTH, {27'd0, tabw});
    apb_access(1'b0, REG_PROMPT_WIDTH, {25'd0, promptw});
  endtask

  function automatic cmd_t mk_cmd(input logic [1:0] op, input logic [7:0] ch,
                                  input logic [10:0] idx);
    cmd_t c;
    c.operation  = op;
    c.char_code  = ch;
    c.cell_index = idx;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned pick;
    pick = $urandom_range(99);
    c.char_code  = 8'($urandom_range(255));
    c.cell_index = 11'($urandom_range(2047));
    if (pick < 1) begin
      c.operation = OP_CLEAR;
    end else if (pick < 15) begin
      c.operation = OP_READ;
      if ($urandom_range(9) != 0) c.cell_index = 11'($urandom_range(CELLS - 1));
    end else if (pick < 18) begin
      c.operation = OP_UNUSED;
    end else begin
      c.operation = OP_PUT;
      pick = $urandom_range(99);
      if (pick < newline_pct) c.char_code = CH_NEWLINE;
      else if (pick < newline_pct + 8) c.char_code = CH_BACKSPACE;
      else if (pick < newline_pct + 14) c.char_code = CH_TAB;
    end
    return c;
  endfunction

  // Reset defaults; the screen must be cleared before any cell is read.
  task automatic test_basic_ops();
    send_cmd(mk_cmd(OP_CLEAR, 8'hA5, 11'h7FF));
    send_cmd(mk_cmd(OP_READ, 8'h00, 11'd0));
    send_cmd(mk_cmd(OP_READ, 8'hFF, 11'd1999));
    send_cmd(mk_cmd(OP_READ, 8'h00, 11'd2000));
    send_cmd(mk_cmd(OP_READ, 8'h00, 11'h7FF));
    send_cmd(mk_cmd(OP_PUT, 8'h00, 11'd0));
    send_cmd(mk_cmd(OP_PUT, 8'hFF, 11'h7FF));
    send_cmd(mk_cmd(OP_PUT, 8'h41, 11'd0));
    send_cmd(mk_cmd(OP_PUT, CH_TAB, 11'd0));
    // Column 7 is inside the prompt, so this backspace does nothing.
    send_cmd(mk_cmd(OP_PUT, CH_BACKSPACE, 11'd0));
    send_cmd(mk_cmd(OP_UNUSED, 8'hFF, 11'h7FF));
    send_cmd(mk_cmd(OP_READ, 8'h00, 11'd1));
    wait_idle();
  endtask

  // Tab saturation, backspace from a full line, wrap and a zero tab width.
  task automatic test_line_edges();
    set_config(8'hFF, 5'd16, 7'd0);
    repeat (6) send_cmd(mk_cmd(OP_PUT, CH_TAB, 11'd0));
    send_cmd(mk_cmd(OP_PUT, CH_BACKSPACE, 11'd0));
    send_cmd(mk_cmd(OP_PUT, 8'h7A, 11'd0));
    send_cmd(mk_cmd(OP_PUT, 8'h71, 11'd0));
    send_cmd(mk_cmd(OP_READ, 8'h00, 11'd79));
    send_cmd(mk_cmd(OP_READ, 8'h00, 11'd80));
    send_cmd(mk_cmd(OP_PUT, CH_NEWLINE, 11'd0));
    set_config(8'h0F, 5'd0, 7'd79);
    send_cmd(mk_cmd(OP_PUT, 8'h78, 11'd0));
    send_cmd(mk_cmd(OP_PUT, CH_TAB, 11'd0));
    send_cmd(mk_cmd(OP_PUT, CH_BACKSPACE, 11'd0));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(8'h00, 5'd1, 7'd0);
        1: set_config(8'hFF, 5'd16, 7'd79);
        default: set_config(8'($urandom_range(255)), 5'($urandom_range(16, 1)),
                            7'($urandom_range(79)));
      endcase
      idle_pct    = (phase == 2) ? 0 : 30;
      // A phase with few newlines lets lines fill up and wrap.
      newline_pct = (phase == 3) ? 3 : 18;
      repeat (150) send_cmd(random_cmd());
    end
    wait_idle();
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        note_mismatch("result word with nothing pending", 32'd0, {5'd0, result});
      end else begin
        want = pending_words.pop_front();
        if (result.cursor_pos !== want.cursor_pos)
          note_mismatch("cursor_pos", 32'(want.cursor_pos), 32'(result.cursor_pos));
        if (result.read_char !== want.read_char)
          note_mismatch("read_char", 32'(want.read_char), 32'(result.read_char));
        if (result.read_attr !== want.read_attr)
          note_mismatch("read_attr", 32'(want.read_attr), 32'(result.read_attr));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    row_q     = 0;
    col_q     = 0;
    attr_q    = COLOR_ATTR_RST;
    tabw_q    = TAB_WIDTH_RST;
    promptw_q = PROMPT_WIDTH_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_line_edges();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
